@@ design/spadd_pkg.sv @@
// ---------------------------------------------------------------------------
// spadd_pkg
// Shared codes and the command type passed from the front to the back end
// of the sparse polynomial add/merge unit.
// ---------------------------------------------------------------------------
package spadd_pkg;

   localparam int unsigned COEF_W = 16;
   localparam int unsigned EXP_W  = 16;
   localparam int unsigned SUM_W  = COEF_W + 1;
   localparam int unsigned OP_W   = 2;
   localparam int unsigned TERM_W = COEF_W + EXP_W;

   localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
   localparam logic [OP_W-1:0] OP_RUN    = 2'd2;
   localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COEF_W-1:0] coef;
      logic [EXP_W-1:0]  term_exp;
   } cmd_type;

endpackage

@@ design/spadd_front.sv @@
// ---------------------------------------------------------------------------
// spadd_front
// Accepts request beats, drops reserved operation codes and queues the
// remaining commands in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
module spadd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [spadd_pkg::OP_W-1:0]   req_operation,
   input  logic [spadd_pkg::COEF_W-1:0] req_term_coef,
   input  logic [spadd_pkg::EXP_W-1:0]  req_term_exp,
   output logic                        q_valid,
   output spadd_pkg::cmd_type           q_cmd,
   input  logic                        q_pop
);
   import spadd_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_cmd     = entry_ff[rd_ptr_ff];

   // reserved codes are consumed without a queue entry
   assign push = req_valid && req_ready && (req_operation != OP_RSVD);
   assign pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{op: req_operation, coef: req_term_coef,
                                  term_exp: req_term_exp};
      end
   end

endmodule

@@ design/spadd_back.sv @@
// ---------------------------------------------------------------------------
// spadd_back
// Holds both term lists, executes queued loads and runs the sorted merge,
// one merged term at a time into the response register.
// ---------------------------------------------------------------------------
module spadd_back #(
   parameter int unsigned MAX_LIST_TERMS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  spadd_pkg::cmd_type           q_cmd,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [spadd_pkg::SUM_W-1:0]  rsp_out_coef,
   output logic [spadd_pkg::EXP_W-1:0]  rsp_out_exp,
   output logic                        rsp_last_term,
   output logic                        rsp_terms_dropped
);
   import spadd_pkg::*;

   localparam int unsigned AW = (MAX_LIST_TERMS > 1) ? $clog2(MAX_LIST_TERMS) : 1;
   localparam int unsigned CW = $clog2(MAX_LIST_TERMS + 1);
   localparam logic [CW-1:0] CAP = CW'(MAX_LIST_TERMS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_MERGE = 2'd2;

   logic [TERM_W-1:0] mem_a [MAX_LIST_TERMS];
   logic [TERM_W-1:0] mem_b [MAX_LIST_TERMS];
   logic [TERM_W-1:0] rd_a_ff;
   logic [TERM_W-1:0] rd_b_ff;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_a_ff, count_a_in;
   logic [CW-1:0] count_b_ff, count_b_in;
   logic          drop_ff, drop_in;
   logic [CW-1:0] na_ff, na_in;
   logic [CW-1:0] nb_ff, nb_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic          dropped_ff, dropped_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic [EXP_W-1:0] rsp_exp_ff, rsp_exp_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_drop_ff, rsp_drop_in;

   logic             wr_a;
   logic             wr_b;
   logic             a_left;
   logic             b_left;
   logic             take_a;
   logic             take_b;
   logic [EXP_W-1:0] ea;
   logic [EXP_W-1:0] eb;
   logic [SUM_W-1:0] ca;
   logic [SUM_W-1:0] cb;
   logic [SUM_W-1:0] term_coef;
   logic [CW-1:0]    i_next;
   logic [CW-1:0]    j_next;
   logic             is_last;
   logic             out_free;

   assign ea     = rd_a_ff[TERM_W-1:COEF_W];
   assign eb     = rd_b_ff[TERM_W-1:COEF_W];
   assign ca     = {rd_a_ff[COEF_W-1], rd_a_ff[COEF_W-1:0]};
   assign cb     = {rd_b_ff[COEF_W-1], rd_b_ff[COEF_W-1:0]};
   assign a_left = (i_ff < na_ff);
   assign b_left = (j_ff < nb_ff);

   // merge step selection
   always_comb begin
      take_a = 1'b0;
      take_b = 1'b0;
      priority if (a_left && b_left) begin
         priority if (ea > eb) begin
            take_a = 1'b1;
         end else if (ea < eb) begin
            take_b = 1'b1;
         end else begin
            take_a = 1'b1;
            take_b = 1'b1;
         end
      end else if (a_left) begin
         take_a = 1'b1;
      end else begin
         take_b = 1'b1;
      end
   end

   assign term_coef = (take_a && take_b) ? (ca + cb) : (take_a ? ca : cb);
   assign i_next    = i_ff + CW'(take_a);
   assign j_next    = j_ff + CW'(take_b);
   assign is_last   = !(i_next < na_ff) && !(j_next < nb_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      drop_in      = drop_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_coef_in  = rsp_coef_ff;
      rsp_exp_in   = rsp_exp_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;
      q_pop        = 1'b0;
      wr_a         = 1'b0;
      wr_b         = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_cmd.op)
                  OP_LOAD_A: begin
                     if (count_a_ff < CAP) begin
                        wr_a       = 1'b1;
                        count_a_in = count_a_ff + CW'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  OP_LOAD_B: begin
                     if (count_b_ff < CAP) begin
                        wr_b       = 1'b1;
                        count_b_in = count_b_ff + CW'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  OP_RUN: begin
                     na_in      = count_a_ff;
                     nb_in      = count_b_ff;
                     i_in       = '0;
                     j_in       = '0;
                     dropped_in = drop_ff;
                     count_a_in = '0;
                     count_b_in = '0;
                     drop_in    = 1'b0;
                     if ((count_a_ff != '0) || (count_b_ff != '0)) begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_coef_in  = term_coef;
               rsp_exp_in   = take_a ? ea : eb;
               rsp_last_in  = is_last;
               rsp_drop_in  = dropped_ff;
               i_in         = i_next;
               j_in         = j_next;
               state_in     = is_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      na_ff       <= na_in;
      nb_ff       <= nb_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      dropped_ff  <= dropped_in;
      rsp_coef_ff <= rsp_coef_in;
      rsp_exp_ff  <= rsp_exp_in;
      rsp_last_ff <= rsp_last_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   // term lists, exponent in the upper half
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[count_a_ff[AW-1:0]] <= {q_cmd.term_exp, q_cmd.coef};
      end
      rd_a_ff <= mem_a[i_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[count_b_ff[AW-1:0]] <= {q_cmd.term_exp, q_cmd.coef};
      end
      rd_b_ff <= mem_b[j_ff[AW-1:0]];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_coef      = rsp_coef_ff;
   assign rsp_out_exp       = rsp_exp_ff;
   assign rsp_last_term     = rsp_last_ff;
   assign rsp_terms_dropped = rsp_drop_ff;

endmodule

@@ design/sparse_poly_add_merge_unit.sv @@
// ---------------------------------------------------------------------------
// sparse_poly_add_merge_unit
// Adds two sparse polynomials held as descending-exponent term lists.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: each beat carries an operation, a coefficient and an
//   exponent. Load beats append the term to list A or list B (up to
//   MAX_LIST_TERMS each; extra terms are dropped and a sticky flag is set).
//   A run beat merges both lists and then empties them. Reserved codes are
//   consumed with no effect.
//   rsp channel: one beat per merged term, larger exponent first, equal
//   exponents summed into a 17-bit coefficient; the last beat of a run has
//   last_term set and every beat of a run carries the drop flag as it stood
//   when the run began. A run on two empty lists gives no beats.
//   Timing: a two-entry command queue sits in front of the list engine.
//   A load is executed when it reaches the queue head and the engine is
//   idle. A run steps through a read state, the registered list read
//   ahead of each compare, and a merge state for every term, so a new
//   term is not compared before the last one is written.
//   Reset: both lists empty, drop flag clear, queue empty, no rsp beat.
//   Stall: a held rsp beat stalls the merge; the queue keeps taking beats
//   until it is full, then req_ready drops.
// ---------------------------------------------------------------------------
module sparse_poly_add_merge_unit #(
   parameter int unsigned MAX_LIST_TERMS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [spadd_pkg::OP_W-1:0]   req_operation,
   input  logic [spadd_pkg::COEF_W-1:0] req_term_coef,
   input  logic [spadd_pkg::EXP_W-1:0]  req_term_exp,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [spadd_pkg::SUM_W-1:0]  rsp_out_coef,
   output logic [spadd_pkg::EXP_W-1:0]  rsp_out_exp,
   output logic                        rsp_last_term,
   output logic                        rsp_terms_dropped
);
   import spadd_pkg::*;

   logic    q_valid;
   cmd_type q_cmd;
   logic    q_pop;

   spadd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_term_coef (req_term_coef),
      .req_term_exp  (req_term_exp),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .q_pop         (q_pop)
   );

   spadd_back #(
      .MAX_LIST_TERMS (MAX_LIST_TERMS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_cmd             (q_cmd),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_coef      (rsp_out_coef),
      .rsp_out_exp       (rsp_out_exp),
      .rsp_last_term     (rsp_last_term),
      .rsp_terms_dropped (rsp_terms_dropped)
   );

endmodule

@@ design/spadd_checker.sv @@
// ---------------------------------------------------------------------------
// spadd_checker
// Port-level checks for the sparse polynomial add/merge unit.
// ---------------------------------------------------------------------------
module spadd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [spadd_pkg::OP_W-1:0]   req_operation,
   input logic [spadd_pkg::COEF_W-1:0] req_term_coef,
   input logic [spadd_pkg::EXP_W-1:0]  req_term_exp,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [spadd_pkg::SUM_W-1:0]  rsp_out_coef,
   input logic [spadd_pkg::EXP_W-1:0]  rsp_out_exp,
   input logic                        rsp_last_term,
   input logic                        rsp_terms_dropped
);

   // held beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_coef) &&
      $stable(rsp_out_exp) && $stable(rsp_last_term) && $stable(rsp_terms_dropped))
      else $error("rsp beat changed while stalled");

   // valid beat carries a known payload
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_out_coef, rsp_out_exp, rsp_last_term,
                                 rsp_terms_dropped}))
      else $error("rsp beat with unknown payload");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_reset_req: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready after reset");

endmodule

bind sparse_poly_add_merge_unit spadd_checker u_spadd_checker (.*);
